[rtl/htqp_pkg.sv]
// Package for the triangular-probing hash table: widths, codes, types.
// No dependencies.
package htqp_pkg;
  localparam int SLOTS_DEF = 256;
  localparam int KEY_BITS_DEF = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int SIZE_LOG2_W = 4;
  localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RST = 4'd8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NEW   = 2'd0,
    ST_FOUND = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_TOMB  = 2'd1,
    MARK_LIVE  = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_t;
endpackage

[rtl/htqp_mem.sv]
// Slot store of the triangular-probing hash table: key, value, mark RAMs.
// Depends on htqp_pkg. Marks are cleared by a sweep after reset.
module htqp_mem #(
  parameter int SLOTS = htqp_pkg::SLOTS_DEF,
  parameter int KEY_BITS = htqp_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = htqp_pkg::VALUE_BITS_DEF,
  localparam int AW = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic [AW-1:0]         rd_addr,
  output logic [KEY_BITS-1:0]   rd_key,
  output logic [VALUE_BITS-1:0] rd_value,
  output htqp_pkg::mark_t       rd_mark,
  input  logic                  wr_kv,
  input  logic                  wr_val,
  input  logic                  wr_mark,
  input  logic [AW-1:0]         wr_addr,
  input  logic [KEY_BITS-1:0]   wr_key,
  input  logic [VALUE_BITS-1:0] wr_value,
  input  htqp_pkg::mark_t       wr_mark_d
);
  logic [KEY_BITS-1:0]   key_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];
  htqp_pkg::mark_t       mark_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_kv) key_mem[wr_addr] <= wr_key;
    if (wr_kv || wr_val) val_mem[wr_addr] <= wr_value;
    if (wr_mark) mark_mem[wr_addr] <= wr_mark_d;
    rd_key <= key_mem[rd_addr];
    rd_value <= val_mem[rd_addr];
    rd_mark <= mark_mem[rd_addr];
  end
endmodule

[rtl/hash_table_quadratic_probe_core.sv]
// channel | signals                                   | role
// in      | in_valid/in_ready, cmd key home_hash new_value | command
// out     | out_valid/out_ready, status value_out entries_used | result
// cfg     | cfg_valid/cfg_ready, cfg_size_log2        | table size
// One item at a time: each probe is a read state then a check state; S_DONE
// writes back and S_OUT presents the result, so the next item is accepted
// only after that; the number of probes is set by the slots the key visits.
// After reset a mark clear sweep empties all SLOTS slots; in_ready stays low.
// A waiting result holds the block until out_ready; cfg is always ready.
// Depends on htqp_pkg, htqp_mem.
module hash_table_quadratic_probe_core #(
  parameter int SLOTS = htqp_pkg::SLOTS_DEF,
  parameter int KEY_BITS = htqp_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = htqp_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_cmd,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [31:0]           in_home_hash,
  input  logic [VALUE_BITS-1:0] in_new_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [VALUE_BITS-1:0] out_value_out,
  output logic [7:0]            out_entries_used,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_size_log2
);
  localparam int AW = $clog2(SLOTS);
  localparam int CW = AW + 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_CHECK = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_NEW  = 2'd1,
    ACT_REPL = 2'd2,
    ACT_TOMB = 2'd3
  } act_t;

  state_t state_r, state_nxt;
  logic [3:0] size_log2_r;
  logic [7:0] count_r, count_nxt;
  logic [AW-1:0] clr_r;
  logic [1:0] cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VALUE_BITS-1:0] nval_r;
  logic [AW-1:0] slot_r, slot_nxt, step_r, step_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic tomb_r, tomb_nxt;
  logic [AW-1:0] tslot_r, tslot_nxt;
  logic [1:0] st_r, st_nxt;
  logic [VALUE_BITS-1:0] vo_r, vo_nxt;
  logic [AW-1:0] hit_r, hit_nxt;
  act_t act_r, act_nxt;
  logic [AW-1:0] mask;
  logic [CW-1:0] sz;
  logic [3:0] lg;

  logic [KEY_BITS-1:0] rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  htqp_pkg::mark_t rd_mark, wr_mark_d;
  logic wr_kv, wr_val, wr_mark;
  logic [AW-1:0] wr_addr;

  always_comb begin
    lg = (size_log2_r < 4'd2) ? 4'd2 : size_log2_r;
    if (32'd1 << lg > 32'(SLOTS)) sz = CW'(SLOTS);
    else sz = CW'(32'd1 << lg);
  end
  assign mask = AW'(sz - CW'(1));

  htqp_mem #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_mem (
    .clk(clk), .rd_addr(slot_r), .rd_key(rd_key), .rd_value(rd_value),
    .rd_mark(rd_mark), .wr_kv(wr_kv), .wr_val(wr_val), .wr_mark(wr_mark),
    .wr_addr(wr_addr), .wr_key(key_r), .wr_value(nval_r), .wr_mark_d(wr_mark_d)
  );

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_value_out = vo_r;
  assign out_entries_used = count_r;

  always_comb begin
    wr_kv = 1'b0;
    wr_val = 1'b0;
    wr_mark = 1'b0;
    wr_addr = hit_r;
    wr_mark_d = htqp_pkg::MARK_LIVE;
    if (state_r == S_CLEAR) begin
      wr_mark = 1'b1;
      wr_addr = clr_r;
      wr_mark_d = htqp_pkg::MARK_EMPTY;
    end else if (state_r == S_DONE) begin
      case (act_r)
        ACT_NEW: begin
          wr_kv = 1'b1;
          wr_mark = 1'b1;
        end
        ACT_REPL: wr_val = 1'b1;
        ACT_TOMB: begin
          wr_mark = 1'b1;
          wr_mark_d = htqp_pkg::MARK_TOMB;
        end
        default: ;
      endcase
    end
  end

  logic room, last, is_live, is_match;
  always_comb begin
    state_nxt = state_r;
    slot_nxt = slot_r;
    step_nxt = step_r;
    idx_nxt = idx_r;
    tomb_nxt = tomb_r;
    tslot_nxt = tslot_r;
    st_nxt = st_r;
    vo_nxt = vo_r;
    hit_nxt = hit_r;
    act_nxt = act_r;
    count_nxt = count_r;
    room = ({1'b0, count_r} + 9'd1) <= 9'(sz >> 1);
    last = (idx_r + CW'(1) == sz);
    is_live = (rd_mark == htqp_pkg::MARK_LIVE);
    is_match = is_live && (rd_key == key_r);
    case (state_r)
      S_CLEAR: if (clr_r == AW'(SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) begin
        slot_nxt = AW'(in_home_hash) & mask;
        step_nxt = AW'(1);
        idx_nxt = '0;
        tomb_nxt = 1'b0;
        st_nxt = htqp_pkg::ST_MISS;
        vo_nxt = '0;
        act_nxt = ACT_NONE;
        state_nxt = (in_cmd == htqp_pkg::CMD_NONE) ? S_DONE : S_READ;
      end
      S_READ: state_nxt = S_CHECK;
      S_CHECK: begin
        state_nxt = S_READ;
        slot_nxt = (slot_r + step_r) & mask;
        step_nxt = step_r + AW'(1);
        idx_nxt = idx_r + CW'(1);
        if (cmd_r == htqp_pkg::CMD_INSERT) begin
          if (rd_mark == htqp_pkg::MARK_EMPTY || (last && !is_match &&
              (tomb_r || rd_mark == htqp_pkg::MARK_TOMB))) begin
            state_nxt = S_DONE;
            if (!room) st_nxt = htqp_pkg::ST_FULL;
            else begin
              st_nxt = htqp_pkg::ST_NEW;
              act_nxt = ACT_NEW;
              hit_nxt = (tomb_r || rd_mark != htqp_pkg::MARK_EMPTY) ? tslot_r : slot_r;
              if (!tomb_r && rd_mark != htqp_pkg::MARK_EMPTY) hit_nxt = slot_r;
              count_nxt = count_r + 8'd1;
            end
          end else if (is_match) begin
            state_nxt = S_DONE;
            st_nxt = htqp_pkg::ST_FOUND;
            vo_nxt = rd_value;
            act_nxt = ACT_REPL;
            hit_nxt = slot_r;
          end else if (rd_mark == htqp_pkg::MARK_TOMB && !tomb_r) begin
            tomb_nxt = 1'b1;
            tslot_nxt = slot_r;
          end else if (last) begin
            state_nxt = S_DONE;
            st_nxt = htqp_pkg::ST_FULL;
          end
        end else begin
          if (is_match) begin
            state_nxt = S_DONE;
            st_nxt = htqp_pkg::ST_FOUND;
            vo_nxt = rd_value;
            hit_nxt = slot_r;
            if (cmd_r == htqp_pkg::CMD_REMOVE) begin
              act_nxt = ACT_TOMB;
              if (count_r != 8'd0) count_nxt = count_r - 8'd1;
            end
          end else if (rd_mark == htqp_pkg::MARK_EMPTY || last) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      count_r <= '0;
      size_log2_r <= htqp_pkg::SIZE_LOG2_RST;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_r + AW'(1);
      count_r <= count_nxt;
      if (cfg_valid) size_log2_r <= cfg_size_log2;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
      nval_r <= in_new_value;
    end
    slot_r <= slot_nxt;
    step_r <= step_nxt;
    idx_r <= idx_nxt;
    tomb_r <= tomb_nxt;
    tslot_r <= tslot_nxt;
    st_r <= st_nxt;
    vo_r <= vo_nxt;
    hit_r <= hit_nxt;
    act_r <= act_nxt;
  end
endmodule

[rtl/htqp_checker.sv]
// Port-level checks for hash_table_quadratic_probe_core, bound to the top.
// Depends on the top level's ports only.
module htqp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [7:0] out_entries_used
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entries_used <= 8'd128) else $error("count too big");
endmodule

bind hash_table_quadratic_probe_core htqp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_entries_used(out_entries_used)
);
